// ----- rtl/smeu_pkg.sv -----
// Shared types and constants for the stack machine execute unit.
// Used by smeu_ctrl, smeu_dp and stack_machine_execute_unit.
package smeu_pkg;

  localparam logic [4:0] CMD_FINISH   = 5'd0;
  localparam logic [4:0] CMD_PUSH     = 5'd1;
  localparam logic [4:0] CMD_POP      = 5'd2;
  localparam logic [4:0] CMD_ADD      = 5'd3;
  localparam logic [4:0] CMD_SUB      = 5'd4;
  localparam logic [4:0] CMD_MUL      = 5'd5;
  localparam logic [4:0] CMD_DIV      = 5'd6;
  localparam logic [4:0] CMD_CMP      = 5'd7;
  localparam logic [4:0] CMD_JUMP     = 5'd8;
  localparam logic [4:0] CMD_JE       = 5'd9;
  localparam logic [4:0] CMD_JNE      = 5'd10;
  localparam logic [4:0] CMD_JG       = 5'd11;
  localparam logic [4:0] CMD_JGE      = 5'd12;
  localparam logic [4:0] CMD_JL       = 5'd13;
  localparam logic [4:0] CMD_JLE      = 5'd14;
  localparam logic [4:0] CMD_PUSHTO   = 5'd15;
  localparam logic [4:0] CMD_PUSHFROM = 5'd16;
  localparam logic [4:0] CMD_OUT      = 5'd17;
  localparam logic [4:0] CMD_IN       = 5'd18;
  localparam logic [4:0] CMD_CALL     = 5'd19;
  localparam logic [4:0] CMD_RET      = 5'd20;

  localparam logic [2:0] ERR_OK    = 3'd0;
  localparam logic [2:0] ERR_UNDER = 3'd1;
  localparam logic [2:0] ERR_OVER  = 3'd2;
  localparam logic [2:0] ERR_DIVZ  = 3'd3;
  localparam logic [2:0] ERR_RET   = 3'd4;
  localparam logic [2:0] ERR_BAD   = 3'd5;

  typedef struct packed {
    logic accept;
    logic cap1;
    logic cap2;
    logic div_start;
    logic commit;
    logic clear;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic need_div;
    logic div_done;
    logic out_free;
  } dp_status_t;

endpackage

// ----- rtl/stack_machine_execute_unit.sv -----
// Execute unit of a 32-bit stack machine, one decoded instruction per transfer.
// Input channel: in_valid_i / in_stall_o with command_i, reg_index_i, immediate_i,
// jump_target_i, console_value_i. Result channel: res_valid_o / res_stall_i with
// next_pc_o, out_value_o, out_valid_o, halted_o, error_code_o; one result per item.
// Each item passes through accept, two operand reads, a check, an optional divide
// wait (one quotient bit per cycle in the divider) and commit before its result is valid.
// One item is in work at a time; next input accepted the cycle after commit.
// Reads of the data stack memory, which has a single read port, take the top word
// and then the second word in turn.
// After reset the register file is zeroed by a clearing pass over every entry,
// during which in_stall_o stays high; pc, stack depths and halt flag reset at once.
// The result register holds while res_stall_i is high; a new item may be taken
// and worked on meanwhile, and waits at commit until the result register frees.
// Depends on smeu_pkg, smeu_ctrl, smeu_dp, smeu_ram.
module stack_machine_execute_unit #(
  parameter int REG_COUNT          = 128,
  parameter int DATA_STACK_DEPTH   = 64,
  parameter int RETURN_STACK_DEPTH = 16,
  parameter int PC_BITS            = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [4:0]  command_i,
  input  logic [6:0]  reg_index_i,
  input  logic [31:0] immediate_i,
  input  logic [15:0] jump_target_i,
  input  logic [31:0] console_value_i,
  output logic        res_valid_o,
  input  logic        res_stall_i,
  output logic [15:0] next_pc_o,
  output logic [31:0] out_value_o,
  output logic        out_valid_o,
  output logic        halted_o,
  output logic [2:0]  error_code_o
);
  import smeu_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  smeu_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .status_i(status), .cmd_o(cmd)
  );

  smeu_dp #(
    .REG_COUNT(REG_COUNT), .DATA_STACK_DEPTH(DATA_STACK_DEPTH),
    .RETURN_STACK_DEPTH(RETURN_STACK_DEPTH), .PC_BITS(PC_BITS)
  ) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .status_o(status),
    .command_i, .reg_index_i, .immediate_i, .jump_target_i, .console_value_i,
    .res_valid_o, .res_stall_i, .next_pc_o, .out_value_o, .out_valid_o,
    .halted_o, .error_code_o
  );

endmodule

// ----- rtl/smeu_ram.sv -----
// Generic single write, single read RAM with registered read data.
// No dependencies.
module smeu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/smeu_ctrl.sv -----
// Sequencer for the execute unit: clear pass, operand reads, divide wait, commit.
// Depends on smeu_pkg.
module smeu_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  smeu_pkg::dp_status_t status_i,
  output smeu_pkg::ctrl_cmd_t  cmd_o
);
  import smeu_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_RD1   = 3'd2;
  localparam logic [2:0] S_RD2   = 3'd3;
  localparam logic [2:0] S_CHK   = 3'd4;
  localparam logic [2:0] S_DIV   = 3'd5;
  localparam logic [2:0] S_EXEC  = 3'd6;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (status_i.clear_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_RD1;
        end
      end
      S_RD1: begin
        cmd_o.cap1 = 1'b1;
        state_d    = S_RD2;
      end
      S_RD2: begin
        cmd_o.cap2 = 1'b1;
        state_d    = S_CHK;
      end
      S_CHK: begin
        if (status_i.need_div) begin
          cmd_o.div_start = 1'b1;
          state_d         = S_DIV;
        end else begin
          state_d = S_EXEC;
        end
      end
      S_DIV: begin
        if (status_i.div_done) state_d = S_EXEC;
      end
      S_EXEC: begin
        if (status_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

  a_div_enters_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_start |=> (state_q == S_DIV))
    else $error("divide start did not enter wait");
  a_commit_returns_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |=> !in_stall_o)
    else $error("commit did not return to idle");
  a_clear_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_CLEAR) |=> (state_q != S_CLEAR))
    else $error("clear pass re-entered");

endmodule

// ----- rtl/smeu_dp.sv -----
// Datapath: architectural state, stack and register memories, ALU, divider, result reg.
// Depends on smeu_pkg and smeu_ram.
module smeu_dp #(
  parameter int REG_COUNT          = 128,
  parameter int DATA_STACK_DEPTH   = 64,
  parameter int RETURN_STACK_DEPTH = 16,
  parameter int PC_BITS            = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  smeu_pkg::ctrl_cmd_t  cmd_i,
  output smeu_pkg::dp_status_t status_o,
  input  logic [4:0]           command_i,
  input  logic [6:0]           reg_index_i,
  input  logic [31:0]          immediate_i,
  input  logic [15:0]          jump_target_i,
  input  logic [31:0]          console_value_i,
  output logic                 res_valid_o,
  input  logic                 res_stall_i,
  output logic [15:0]          next_pc_o,
  output logic [31:0]          out_value_o,
  output logic                 out_valid_o,
  output logic                 halted_o,
  output logic [2:0]           error_code_o
);
  import smeu_pkg::*;

  localparam int DAW = $clog2(DATA_STACK_DEPTH);
  localparam int DDW = $clog2(DATA_STACK_DEPTH + 1);
  localparam int RAW = $clog2(RETURN_STACK_DEPTH);
  localparam int RDW = $clog2(RETURN_STACK_DEPTH + 1);
  localparam int FAW = $clog2(REG_COUNT);

  // latched item
  logic [4:0]  cmd_q;
  logic [6:0]  reg_q;
  logic [31:0] imm_q, con_q;
  logic [15:0] tgt_q;
  logic [31:0] top_q, low_q, rfv_q;
  logic [PC_BITS-1:0] rsv_q;

  // architectural state
  logic [PC_BITS-1:0] pc_q, pc_d;
  logic [DDW-1:0]     dd_q, dd_d;
  logic [RDW-1:0]     rd_q, rd_d;
  logic               halted_q, halted_d;
  logic [FAW-1:0]     clr_q;

  // divider
  logic [31:0] dv_rem_q, dv_quo_q, dv_b_q;
  logic        dv_neg_q;
  logic [5:0]  dv_cnt_q;
  logic [32:0] dv_shift, dv_diff;

  // result register
  logic        ovld_q;
  logic [15:0] rpc_q;
  logic [31:0] rval_q;
  logic        rvv_q, rhalt_q;
  logic [2:0]  rerr_q;

  // memory ports
  logic               ds_we, rf_we, rs_we;
  logic [DAW-1:0]     ds_wa, ds_ra;
  logic [31:0]        ds_wd, ds_rd;
  logic [FAW-1:0]     rf_wa, rf_ra;
  logic [31:0]        rf_wd, rf_rd;
  logic [RAW-1:0]     rs_wa, rs_ra;
  logic [PC_BITS-1:0] rs_wd, rs_rd;

  logic               x_ds_we, x_rf_we, x_rs_we;
  logic [DAW-1:0]     x_ds_wa;
  logic [31:0]        x_ds_wd, x_rf_wd, x_oval;
  logic [2:0]         x_err;
  logic               x_ovld;

  logic [PC_BITS-1:0] pc_p1, pc_p5, pc_p9, tgt_pc;
  logic               reg_bad, neg, zero, take;
  logic [31:0]        alu_r, quo_s, prod;
  logic [63:0]        prod_w;

  smeu_ram #(.WIDTH(32), .DEPTH(DATA_STACK_DEPTH)) u_dstack (
    .clk_i, .we_i(ds_we), .waddr_i(ds_wa), .wdata_i(ds_wd), .raddr_i(ds_ra), .rdata_o(ds_rd)
  );
  smeu_ram #(.WIDTH(32), .DEPTH(REG_COUNT)) u_regs (
    .clk_i, .we_i(rf_we), .waddr_i(rf_wa), .wdata_i(rf_wd), .raddr_i(rf_ra), .rdata_o(rf_rd)
  );
  smeu_ram #(.WIDTH(PC_BITS), .DEPTH(RETURN_STACK_DEPTH)) u_rstack (
    .clk_i, .we_i(rs_we), .waddr_i(rs_wa), .wdata_i(rs_wd), .raddr_i(rs_ra), .rdata_o(rs_rd)
  );

  assign ds_ra = cmd_i.accept ? DAW'(dd_q - DDW'(1)) : DAW'(dd_q - DDW'(2));
  assign rf_ra = FAW'(reg_index_i);
  assign rs_ra = RAW'(rd_q - RDW'(1));

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      cmd_q <= command_i;
      reg_q <= reg_index_i;
      imm_q <= immediate_i;
      tgt_q <= jump_target_i;
      con_q <= console_value_i;
    end
    if (cmd_i.cap1) begin
      top_q <= ds_rd;
      rfv_q <= rf_rd;
      rsv_q <= rs_rd;
    end
    if (cmd_i.cap2) begin
      low_q <= ds_rd;
    end
  end

  // restoring divider on magnitudes, one quotient bit per cycle
  assign dv_shift = {dv_rem_q, dv_quo_q[31]};
  assign dv_diff  = dv_shift - {1'b0, dv_b_q};
  assign quo_s    = dv_neg_q ? (32'd0 - dv_quo_q) : dv_quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_cnt_q <= '0;
    end else if (cmd_i.div_start) begin
      dv_cnt_q <= 6'd32;
    end else if (dv_cnt_q != 6'd0) begin
      dv_cnt_q <= dv_cnt_q - 6'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      dv_rem_q <= '0;
      dv_quo_q <= low_q[31] ? (32'd0 - low_q) : low_q;
      dv_b_q   <= top_q[31] ? (32'd0 - top_q) : top_q;
      dv_neg_q <= low_q[31] ^ top_q[31];
    end else if (dv_cnt_q != 6'd0) begin
      dv_rem_q <= dv_diff[32] ? dv_shift[31:0] : dv_diff[31:0];
      dv_quo_q <= {dv_quo_q[30:0], ~dv_diff[32]};
    end
  end

  assign pc_p1  = pc_q + PC_BITS'(1);
  assign pc_p5  = pc_q + PC_BITS'(5);
  assign pc_p9  = pc_q + PC_BITS'(9);
  assign tgt_pc = PC_BITS'(tgt_q);
  assign reg_bad = (32'(reg_q) >= REG_COUNT);
  assign neg  = top_q[31];
  assign zero = (top_q == 32'd0);
  assign prod_w = 64'(low_q) * 64'(top_q);
  assign prod   = prod_w[31:0];

  always_comb begin
    unique case (cmd_q)
      CMD_JE:  take = zero;
      CMD_JNE: take = !zero;
      CMD_JG:  take = !neg && !zero;
      CMD_JGE: take = !neg;
      CMD_JL:  take = neg;
      default: take = neg || zero;
    endcase
    unique case (cmd_q)
      CMD_ADD: alu_r = low_q + top_q;
      CMD_SUB: alu_r = low_q - top_q;
      CMD_MUL: alu_r = prod;
      CMD_DIV: alu_r = quo_s;
      default: alu_r = ($signed(low_q) < $signed(top_q)) ? 32'd1 :
                       ($signed(top_q) < $signed(low_q)) ? 32'hFFFF_FFFF : 32'd0;
    endcase
  end

  always_comb begin
    pc_d     = pc_q;
    dd_d     = dd_q;
    rd_d     = rd_q;
    halted_d = halted_q;
    x_err    = ERR_OK;
    x_oval   = '0;
    x_ovld   = 1'b0;
    x_ds_we  = 1'b0;
    x_ds_wa  = DAW'(dd_q);
    x_ds_wd  = alu_r;
    x_rf_we  = 1'b0;
    x_rf_wd  = top_q;
    x_rs_we  = 1'b0;
    if (!halted_q) begin
      priority if (cmd_q > CMD_RET) begin
        x_err = ERR_BAD;
      end else if ((cmd_q == CMD_POP || cmd_q == CMD_PUSHTO || cmd_q == CMD_PUSHFROM)
                   && reg_bad) begin
        x_err = ERR_BAD;
      end else if (cmd_q == CMD_FINISH) begin
        halted_d = 1'b1;
        pc_d     = pc_p1;
      end else if (cmd_q == CMD_PUSH || cmd_q == CMD_PUSHFROM || cmd_q == CMD_IN) begin
        if (32'(dd_q) >= DATA_STACK_DEPTH) begin
          x_err = ERR_OVER;
        end else begin
          x_ds_we = 1'b1;
          x_ds_wd = (cmd_q == CMD_PUSH) ? imm_q : (cmd_q == CMD_PUSHFROM) ? rfv_q : con_q;
          dd_d    = dd_q + DDW'(1);
          pc_d    = (cmd_q == CMD_IN) ? pc_p1 : pc_p5;
        end
      end else if (cmd_q == CMD_POP || cmd_q == CMD_OUT) begin
        if (dd_q == '0) begin
          x_err = ERR_UNDER;
        end else begin
          dd_d = dd_q - DDW'(1);
          if (cmd_q == CMD_POP) begin
            x_rf_we = 1'b1;
            pc_d    = pc_p5;
          end else begin
            x_oval = top_q;
            x_ovld = 1'b1;
            pc_d   = pc_p1;
          end
        end
      end else if (cmd_q >= CMD_ADD && cmd_q <= CMD_CMP) begin
        if (dd_q < DDW'(2)) begin
          x_err = ERR_UNDER;
        end else if (cmd_q == CMD_DIV && zero) begin
          x_err = ERR_DIVZ;
        end else begin
          x_ds_we = 1'b1;
          x_ds_wa = DAW'(dd_q - DDW'(2));
          dd_d    = dd_q - DDW'(1);
          pc_d    = pc_p1;
        end
      end else if (cmd_q == CMD_JUMP) begin
        pc_d = tgt_pc;
      end else if (cmd_q >= CMD_JE && cmd_q <= CMD_JLE) begin
        if (dd_q == '0) begin
          x_err = ERR_UNDER;
        end else begin
          dd_d = dd_q - DDW'(1);
          pc_d = take ? tgt_pc : pc_p9;
        end
      end else if (cmd_q == CMD_PUSHTO) begin
        x_rf_we = 1'b1;
        x_rf_wd = imm_q;
        pc_d    = pc_p9;
      end else if (cmd_q == CMD_CALL) begin
        if (32'(rd_q) >= RETURN_STACK_DEPTH) begin
          x_err = ERR_RET;
        end else begin
          x_rs_we = 1'b1;
          rd_d    = rd_q + RDW'(1);
          pc_d    = tgt_pc;
        end
      end else begin
        if (rd_q == '0) begin
          x_err = ERR_RET;
        end else begin
          rd_d = rd_q - RDW'(1);
          pc_d = rsv_q;
        end
      end
    end
  end

  assign ds_we = cmd_i.commit && x_ds_we;
  assign ds_wa = x_ds_wa;
  assign ds_wd = x_ds_wd;
  assign rf_we = cmd_i.clear || (cmd_i.commit && x_rf_we);
  assign rf_wa = cmd_i.clear ? clr_q : FAW'(reg_q);
  assign rf_wd = cmd_i.clear ? 32'd0 : x_rf_wd;
  assign rs_we = cmd_i.commit && x_rs_we;
  assign rs_wa = RAW'(rd_q);
  assign rs_wd = pc_p9;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q     <= '0;
      dd_q     <= '0;
      rd_q     <= '0;
      halted_q <= 1'b0;
      clr_q    <= '0;
      ovld_q   <= 1'b0;
    end else begin
      if (cmd_i.clear) clr_q <= clr_q + FAW'(1);
      if (cmd_i.commit) begin
        if (x_err == ERR_OK) begin
          pc_q <= pc_d;
          dd_q <= dd_d;
          rd_q <= rd_d;
        end
        halted_q <= halted_d;
        ovld_q   <= 1'b1;
      end else if (!res_stall_i) begin
        ovld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      rpc_q   <= 16'((x_err == ERR_OK) ? pc_d : pc_q);
      rval_q  <= x_oval;
      rvv_q   <= x_ovld;
      rhalt_q <= halted_d;
      rerr_q  <= x_err;
    end
  end

  assign status_o.clear_done = (clr_q == FAW'(REG_COUNT - 1));
  assign status_o.need_div   = !halted_q && (cmd_q == CMD_DIV) && !(dd_q < DDW'(2)) && !zero;
  assign status_o.div_done   = (dv_cnt_q == 6'd0);
  assign status_o.out_free   = !ovld_q || !res_stall_i;

  assign res_valid_o  = ovld_q;
  assign next_pc_o    = rpc_q;
  assign out_value_o  = rval_q;
  assign out_valid_o  = rvv_q;
  assign halted_o     = rhalt_q;
  assign error_code_o = rerr_q;

  a_dd_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(dd_q) <= DATA_STACK_DEPTH)
    else $error("data depth out of range");
  a_rd_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(rd_q) <= RETURN_STACK_DEPTH)
    else $error("return depth out of range");
  a_halt_freezes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |=> (halted_q && $stable(pc_q) && $stable(dd_q)))
    else $error("state moved after halt");
  a_err_keeps_pc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && x_err != ERR_OK) |=> ($stable(pc_q) && $stable(rd_q)))
    else $error("error changed state");

endmodule

// ----- test/smeu_checker.sv -----
// Result checker for the stack machine execute unit: keeps its own machine state,
// predicts every result from accepted commands and compares against the result port.
// Depends on smeu_pkg.
`timescale 1ns / 100ps

module smeu_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [4:0]  command_i,
  input  logic [6:0]  reg_index_i,
  input  logic [31:0] immediate_i,
  input  logic [15:0] jump_target_i,
  input  logic [31:0] console_value_i,
  input  logic        res_valid_i,
  input  logic        res_stall_i,
  input  logic [15:0] next_pc_i,
  input  logic [31:0] out_value_i,
  input  logic        out_valid_i,
  input  logic        halted_i,
  input  logic [2:0]  error_code_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          data_depth_o,
  output int          ret_depth_o,
  output logic        halted_o
);
  import smeu_pkg::*;

  localparam int NREG = 128;
  localparam int DDEPTH = 64;
  localparam int RDEPTH = 16;

  typedef struct packed {
    logic [15:0] pc;
    logic [31:0] oval;
    logic        ovalid;
    logic        halt;
    logic [2:0]  err;
  } exec_result_t;

  logic [15:0] pc;
  logic [31:0] dstack [DDEPTH];
  int          ddepth;
  logic [15:0] rstack [RDEPTH];
  int          rdepth;
  logic [31:0] regs [NREG];
  logic        halt;
  exec_result_t expected_q[$];

  assign pending_o = expected_q.size();
  assign data_depth_o = ddepth;
  assign ret_depth_o = rdepth;
  assign halted_o = halt;

  function automatic logic [31:0] sdiv(logic [31:0] n, logic [31:0] d);
    logic [31:0] an, ad, q;
    an = n[31] ? -n : n;
    ad = d[31] ? -d : d;
    q = an / ad;
    return (n[31] != d[31]) ? -q : q;
  endfunction

  task automatic execute(logic [4:0] cmd, logic [6:0] ri, logic [31:0] imm,
                         logic [15:0] tgt, logic [31:0] con);
    exec_result_t r;
    logic [31:0] top, low, v;
    logic take;
    r = '0;
    r.err = ERR_OK;
    if (!halt) begin
      if (cmd > CMD_RET) begin
        r.err = ERR_BAD;
      end else if (cmd == CMD_FINISH) begin
        halt = 1'b1;
        pc = pc + 16'd1;
      end else if (cmd == CMD_PUSH || cmd == CMD_PUSHFROM || cmd == CMD_IN) begin
        if (ddepth >= DDEPTH) r.err = ERR_OVER;
        else begin
          dstack[ddepth] = (cmd == CMD_PUSH) ? imm : (cmd == CMD_PUSHFROM) ? regs[ri] : con;
          ddepth++;
          pc = pc + ((cmd == CMD_IN) ? 16'd1 : 16'd5);
        end
      end else if (cmd == CMD_POP || cmd == CMD_OUT) begin
        if (ddepth == 0) r.err = ERR_UNDER;
        else begin
          ddepth--;
          v = dstack[ddepth];
          if (cmd == CMD_POP) begin
            regs[ri] = v;
            pc = pc + 16'd5;
          end else begin
            r.oval = v;
            r.ovalid = 1'b1;
            pc = pc + 16'd1;
          end
        end
      end else if (cmd >= CMD_ADD && cmd <= CMD_CMP) begin
        if (ddepth < 2) r.err = ERR_UNDER;
        else begin
          top = dstack[ddepth-1];
          low = dstack[ddepth-2];
          if (cmd == CMD_DIV && top == 0) r.err = ERR_DIVZ;
          else begin
            case (cmd)
              CMD_ADD: v = low + top;
              CMD_SUB: v = low - top;
              CMD_MUL: v = low * top;
              CMD_DIV: v = sdiv(low, top);
              default: v = ($signed(low) < $signed(top)) ? 32'd1 :
                           ($signed(top) < $signed(low)) ? 32'hFFFF_FFFF : 32'd0;
            endcase
            dstack[ddepth-2] = v;
            ddepth--;
            pc = pc + 16'd1;
          end
        end
      end else if (cmd == CMD_JUMP) begin
        pc = tgt;
      end else if (cmd >= CMD_JE && cmd <= CMD_JLE) begin
        if (ddepth == 0) r.err = ERR_UNDER;
        else begin
          v = dstack[ddepth-1];
          case (cmd)
            CMD_JE:  take = (v == 0);
            CMD_JNE: take = (v != 0);
            CMD_JG:  take = !v[31] && v != 0;
            CMD_JGE: take = !v[31];
            CMD_JL:  take = v[31];
            default: take = v[31] || v == 0;
          endcase
          ddepth--;
          pc = take ? tgt : pc + 16'd9;
        end
      end else if (cmd == CMD_PUSHTO) begin
        regs[ri] = imm;
        pc = pc + 16'd9;
      end else if (cmd == CMD_CALL) begin
        if (rdepth >= RDEPTH) r.err = ERR_RET;
        else begin
          rstack[rdepth] = pc + 16'd9;
          rdepth++;
          pc = tgt;
        end
      end else begin
        if (rdepth == 0) r.err = ERR_RET;
        else begin
          rdepth--;
          pc = rstack[rdepth];
        end
      end
    end
    r.pc = pc;
    r.halt = halt;
    expected_q.push_back(r);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    exec_result_t e;
    if (!rst_ni) begin
      pc = '0;
      ddepth = 0;
      rdepth = 0;
      halt = 1'b0;
      fail_count_o = 0;
      for (int i = 0; i < DDEPTH; i++) dstack[i] = '0;
      for (int i = 0; i < RDEPTH; i++) rstack[i] = '0;
      for (int i = 0; i < NREG; i++) regs[i] = '0;
      expected_q.delete();
    end else begin
      if (in_valid_i && !in_stall_i)
        execute(command_i, reg_index_i, immediate_i, jump_target_i, console_value_i);
      if (res_valid_i && !res_stall_i) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result transfer");
          fail_count_o++;
        end else begin
          e = expected_q.pop_front();
          if (next_pc_i !== e.pc) begin
            $error("next_pc: expected %0h actual %0h", e.pc, next_pc_i);
            fail_count_o++;
          end
          if (out_value_i !== e.oval) begin
            $error("out_value: expected %0h actual %0h", e.oval, out_value_i);
            fail_count_o++;
          end
          if (out_valid_i !== e.ovalid) begin
            $error("out_valid: expected %0b actual %0b", e.ovalid, out_valid_i);
            fail_count_o++;
          end
          if (halted_i !== e.halt) begin
            $error("halted: expected %0b actual %0b", e.halt, halted_i);
            fail_count_o++;
          end
          if (error_code_i !== e.err) begin
            $error("error_code: expected %0d actual %0d", e.err, error_code_i);
            fail_count_o++;
          end
        end
      end
    end
  end
endmodule

// ----- test/tb_stack_machine_execute_unit.sv -----
// Testbench top for the stack machine execute unit: drives directed and random
// instruction streams with random gaps and stalls; verdict from smeu_checker.
// Depends on smeu_pkg, smeu_checker and the execute unit RTL.
`timescale 1ns / 100ps

module tb_stack_machine_execute_unit;
  import smeu_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [4:0]  command_i = '0;
  logic [6:0]  reg_index_i = '0;
  logic [31:0] immediate_i = '0;
  logic [15:0] jump_target_i = '0;
  logic [31:0] console_value_i = '0;
  logic        res_valid_o;
  logic        res_stall_i = 1'b0;
  logic [15:0] next_pc_o;
  logic [31:0] out_value_o;
  logic        out_valid_o;
  logic        halted_o;
  logic [2:0]  error_code_o;
  int          fail_count, pending, ddepth, rdepth;
  logic        model_halted;
  logic        hold_off = 1'b0;
  int          transfers = 0;

  always #5 clk_i = ~clk_i;

  stack_machine_execute_unit dut (.*);

  smeu_checker checker_i (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .command_i, .reg_index_i,
    .immediate_i, .jump_target_i, .console_value_i, .res_valid_i(res_valid_o),
    .res_stall_i, .next_pc_i(next_pc_o), .out_value_i(out_value_o),
    .out_valid_i(out_valid_o), .halted_i(halted_o), .error_code_i(error_code_o),
    .fail_count_o(fail_count), .pending_o(pending), .data_depth_o(ddepth),
    .ret_depth_o(rdepth), .halted_o(model_halted)
  );

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'hFFFF_FFFF;
      3: return $urandom_range(0, 9);
      default: return $urandom;
    endcase
  endfunction

  // valid stays high across back-to-back transfers; dropped only for a gap
  task automatic send(logic [4:0] cmd, logic [6:0] ri, logic [31:0] imm,
                      logic [15:0] tgt, logic [31:0] con);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i <= cmd;
    reg_index_i <= ri;
    immediate_i <= imm;
    jump_target_i <= tgt;
    console_value_i <= con;
    do @(posedge clk_i); while (in_stall_o);
    transfers++;
  endtask

  // Picks a command that keeps the program mostly well formed.
  task automatic send_random();
    logic [4:0] cmd;
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) cmd = 5'($urandom_range(21, 31));
    else if (r < 1 + 3 && model_halted) cmd = CMD_PUSH;
    else if (ddepth < 2 && r < 50) cmd = ($urandom_range(0, 1)) ? CMD_PUSH : CMD_IN;
    else if (ddepth > 56 && r < 60) cmd = 5'($urandom_range(CMD_ADD, CMD_CMP));
    else cmd = 5'($urandom_range(CMD_PUSH, CMD_RET));
    if (cmd == CMD_FINISH) cmd = CMD_PUSH;
    send(cmd, 7'($urandom), rand_word(), 16'($urandom), rand_word());
  endtask

  initial begin
    res_stall_i <= 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off) res_stall_i <= 1'b1;
      else res_stall_i <= ($urandom_range(0, 99) < 30);
    end
  end

  initial begin
    #20_000_000;
    $display("tb_stack_machine_execute_unit: FAIL");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed: extremes, errors, most commands
    send(CMD_ADD, 0, 0, 0, 0);
    send(CMD_RET, 0, 0, 0, 0);
    send(CMD_PUSH, 0, 32'h8000_0000, 0, 0);
    send(CMD_IN, 0, 0, 0, 32'hFFFF_FFFF);
    send(CMD_DIV, 0, 0, 0, 0);
    send(CMD_PUSH, 0, 32'h0, 0, 0);
    send(CMD_DIV, 0, 0, 0, 0);
    send(CMD_POP, 7'h7F, 0, 0, 0);
    send(CMD_PUSHTO, 7'd0, 32'h7FFF_FFFF, 0, 0);
    send(CMD_PUSHFROM, 7'd0, 0, 0, 0);
    send(CMD_PUSHFROM, 7'h7F, 0, 0, 0);
    send(CMD_SUB, 0, 0, 0, 0);
    send(CMD_MUL, 0, 0, 0, 0);
    send(CMD_CMP, 0, 0, 0, 0);
    send(CMD_JG, 0, 0, 16'hFFFF, 0);
    send(CMD_OUT, 0, 0, 0, 0);
    send(CMD_CALL, 0, 0, 16'hFFFB, 0);
    send(CMD_RET, 0, 0, 0, 0);
    send(CMD_JUMP, 0, 0, 16'hFFFF, 0);
    send(CMD_IN, 0, 0, 0, 0);
    send(CMD_JE, 0, 0, 16'h1234, 0);
    send(5'd31, 0, 0, 0, 0);
    for (int i = 0; i < 17; i++) send(CMD_CALL, 0, 0, 16'($urandom), 0);
    for (int i = 0; i < 17; i++) send(CMD_RET, 0, 0, 0, 0);
    // receiver blocks while commands keep coming
    hold_off = 1'b1;
    fork
      begin
        repeat (200) @(posedge clk_i);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 66; i++) send(CMD_PUSH, 0, $urandom, 0, 0);
    join
    for (int i = 0; i < 1200; i++) send_random();
    send(CMD_FINISH, 0, 0, 0, 0);
    send(CMD_PUSH, 0, 1, 0, 0);
    send(CMD_OUT, 0, 0, 0, 0);
    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    $display("Ran %0d instruction transfers over all commands with stack, return and",
             transfers);
    $display("divide error cases, random gaps and a long result back-pressure window.");
    if (fail_count == 0) $display("tb_stack_machine_execute_unit: PASS");
    else $display("tb_stack_machine_execute_unit: FAIL");
    $finish;
  end
endmodule

// ----- stack_machine_execute_unit.f -----
rtl/smeu_pkg.sv
rtl/smeu_ram.sv
rtl/smeu_ctrl.sv
rtl/smeu_dp.sv
rtl/stack_machine_execute_unit.sv
test/smeu_checker.sv
test/tb_stack_machine_execute_unit.sv
